@@ rtl/phre_pkg.sv @@
// ----------------------------------------------------------------------------
// phre_pkg
// Types, constants and helpers shared by the printable-run hex escaper.
// ----------------------------------------------------------------------------
package phre_pkg;

	localparam int QUEUE_DEPTH = 2;
	localparam int MAX_CHARS   = 4;
	localparam int CHAR_IDX_W  = $clog2(MAX_CHARS);

	localparam logic [7:0] CH_OPEN  = 8'h3C; // '<'
	localparam logic [7:0] CH_CLOSE = 8'h3E; // '>'
	localparam logic [7:0] CH_SPACE = 8'h20; // ' '

	typedef struct packed {
		logic [7:0] in_byte;
		logic       end_of_buffer;
	} item_t;

	typedef struct packed {
		logic [7:0] out_char;
		logic       last_of_item;
	} text_t;

	// one decoded request: up to four characters and the index of the last one
	typedef struct packed {
		logic [MAX_CHARS-1:0][7:0] chars;
		logic [CHAR_IDX_W-1:0]     last_idx;
	} cmd_t;

	function automatic logic [7:0] hex_char(input logic [3:0] d);
		logic [7:0] r;
		if (d < 4'd10) begin
			r = 8'h30 + {4'd0, d};
		end else begin
			r = 8'h37 + {4'd0, d};
		end
		return r;
	endfunction

	function automatic logic is_printable(input logic [7:0] b);
		return ((b >= 8'h20) && (b <= 8'h7E)) || ((b >= 8'hA0) && (b <= 8'hFE));
	endfunction

endpackage

@@ rtl/phre_front.sv @@
// ----------------------------------------------------------------------------
// phre_front
// Accepts input bytes, tracks the open hex run, and builds the character
// sequence for each byte as one command for the queue.
// ----------------------------------------------------------------------------
module phre_front import phre_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  item_valid,
	output logic  item_stall,
	input  item_t item,
	input  logic  q_full,
	output logic  q_push,
	output cmd_t  q_data
);

	logic                  hex_run_open_q;
	logic                  open_next;
	logic [CHAR_IDX_W-1:0] n;

	assign item_stall = q_full;
	assign q_push     = item_valid && !q_full;

	always_comb begin
		q_data.chars = '0;
		n            = '0;
		if (is_printable(item.in_byte)) begin
			if (hex_run_open_q) begin
				q_data.chars[0] = CH_CLOSE;
				q_data.chars[1] = item.in_byte;
				n               = CHAR_IDX_W'(1);
			end else begin
				q_data.chars[0] = item.in_byte;
			end
			open_next = 1'b0;
		end else begin
			q_data.chars[0] = hex_run_open_q ? CH_SPACE : CH_OPEN;
			q_data.chars[1] = hex_char(item.in_byte[7:4]);
			q_data.chars[2] = hex_char(item.in_byte[3:0]);
			n               = CHAR_IDX_W'(2);
			open_next       = 1'b1;
		end
		// final byte closes any open run
		if (item.end_of_buffer && open_next) begin
			n                = n + 1'b1;
			q_data.chars[n]  = CH_CLOSE;
			open_next        = 1'b0;
		end
		q_data.last_idx = n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hex_run_open_q <= 1'b0;
		end else if (q_push) begin
			hex_run_open_q <= open_next;
		end
	end

endmodule

@@ rtl/phre_queue.sv @@
// ----------------------------------------------------------------------------
// phre_queue
// Small register queue of decoded commands between front and back.
// ----------------------------------------------------------------------------
module phre_queue import phre_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_data,
	input  logic pop,
	output cmd_t head,
	output logic full,
	output logic empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	cmd_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full  = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ rtl/phre_back.sv @@
// ----------------------------------------------------------------------------
// phre_back
// Walks the head command one character per cycle, unless stalled, into text_q.
// ----------------------------------------------------------------------------
module phre_back import phre_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  cmd_t  head,
	input  logic  q_empty,
	output logic  q_pop,
	output logic  text_valid,
	input  logic  text_stall,
	output text_t text
);

	logic [CHAR_IDX_W-1:0] idx_q;
	logic                  text_valid_q;
	text_t                 text_q;
	logic                  advance;
	logic                  at_last;

	assign advance    = !q_empty && (!text_valid_q || !text_stall);
	assign at_last    = (idx_q == head.last_idx);
	assign q_pop      = advance && at_last;
	assign text_valid = text_valid_q;
	assign text       = text_q;

	always_ff @(posedge clk) begin
		if (advance) begin
			text_q.out_char     <= head.chars[idx_q];
			text_q.last_of_item <= at_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q        <= '0;
			text_valid_q <= 1'b0;
		end else if (advance) begin
			text_valid_q <= 1'b1;
			idx_q        <= at_last ? '0 : idx_q + 1'b1;
		end else if (!text_stall) begin
			text_valid_q <= 1'b0;
		end
	end

endmodule

@@ rtl/printable_run_hex_escaper.sv @@
// An accepted byte is written into the command queue, then its characters are
// loaded into the output register, one character per cycle while text_stall is
// low; a byte gives 1 to 4 characters (printable 1-2, non-printable 3, plus 1
// when the final byte closes a run). Input takes a byte per cycle while the
// command queue has room. Reset clears the run flag, queue and output valid flag.
// ----------------------------------------------------------------------------
// printable_run_hex_escaper
// Passes printable bytes through and writes runs of other bytes as <HH HH>.
// ----------------------------------------------------------------------------
module printable_run_hex_escaper import phre_pkg::*; #(
	parameter int QDEPTH = QUEUE_DEPTH
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  item_valid,
	output logic  item_stall,
	input  item_t item,
	output logic  text_valid,
	input  logic  text_stall,
	output text_t text
);

	logic q_push;
	logic q_pop;
	logic q_full;
	logic q_empty;
	cmd_t q_in;
	cmd_t q_head;

	phre_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_data     (q_in)
	);

	phre_queue #(
		.DEPTH (QDEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_in),
		.pop       (q_pop),
		.head      (q_head),
		.full      (q_full),
		.empty     (q_empty)
	);

	phre_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (q_head),
		.q_empty    (q_empty),
		.q_pop      (q_pop),
		.text_valid (text_valid),
		.text_stall (text_stall),
		.text       (text)
	);

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the printable-run hex escaper. Bytes are streamed
// in as buffers; a local predictor builds the expected character stream and
// every output character is compared in order, under four idle/stall phases.
// ----------------------------------------------------------------------------
module tb_top;
	import phre_pkg::*;

	localparam logic [0:15][7:0] HEX_DIGITS = "0123456789ABCDEF";
	localparam int MAX_PRINTED = 20;

	logic  clk;
	logic  arst_n;
	logic  item_valid;
	logic  item_stall;
	item_t item;
	logic  text_valid;
	logic  text_stall;
	text_t text;

	item_t pending_bytes[$];
	text_t expected_text[$];
	logic  run_open;
	logic  item_taken;
	int    idle_pct;
	int    stall_pct;
	int    errors;
	int    bytes_queued;
	int    bytes_taken;
	int    chars_checked;
	int    escaped_bytes;
	int    buffers_closed;

	printable_run_hex_escaper u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.text_valid (text_valid),
		.text_stall (text_stall),
		.text       (text)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	task automatic report_mismatch(input string what, input logic [7:0] got,
			input logic [7:0] want);
		if (errors < MAX_PRINTED) begin
			$display("%0t mismatch: %s got %02h expected %02h", $time, what, got, want);
		end
		errors++;
	endtask

	// expected characters for one accepted byte, run flag updated
	function automatic void escape_request(input item_t req);
		logic [7:0] b;
		logic [7:0] chars[4];
		int         n;
		text_t      t;
		b = req.in_byte;
		n = 0;
		if ((b >= 8'h20 && b <= 8'h7E) || (b >= 8'hA0 && b <= 8'hFE)) begin
			if (run_open) begin
				chars[n++] = CH_CLOSE;
				run_open = 1'b0;
			end
			chars[n++] = b;
		end else begin
			chars[n++] = run_open ? CH_SPACE : CH_OPEN;
			chars[n++] = HEX_DIGITS[b[7:4]];
			chars[n++] = HEX_DIGITS[b[3:0]];
			run_open = 1'b1;
			escaped_bytes++;
		end
		if (req.end_of_buffer) begin
			buffers_closed++;
			if (run_open) begin
				chars[n++] = CH_CLOSE;
				run_open = 1'b0;
			end
		end
		for (int i = 0; i < n; i++) begin
			t.out_char     = chars[i];
			t.last_of_item = (i == n - 1);
			expected_text.push_back(t);
		end
	endfunction

	// sample at the rising edge: record accepted requests, check characters
	always @(posedge clk) begin
		item_taken = 1'b0;
		if (arst_n) begin
			if (item_valid && !item_stall) begin
				item_taken = 1'b1;
				bytes_taken++;
				escape_request(item);
			end
			if (text_valid && !text_stall) begin
				if (expected_text.size() == 0) begin
					report_mismatch("unexpected character", text.out_char, 8'h00);
				end else begin
					text_t want;
					want = expected_text.pop_front();
					chars_checked++;
					if (text.out_char !== want.out_char) begin
						report_mismatch("out_char", text.out_char, want.out_char);
					end
					if (text.last_of_item !== want.last_of_item) begin
						report_mismatch("last_of_item", {7'd0, text.last_of_item},
							{7'd0, want.last_of_item});
					end
				end
			end
		end
	end

	// drive at the falling edge; a request is held until it is taken
	always @(negedge clk) begin
		if (arst_n) begin
			if (!item_valid || item_taken) begin
				if (pending_bytes.size() > 0 && $urandom_range(99) >= idle_pct) begin
					item       <= pending_bytes.pop_front();
					item_valid <= 1'b1;
				end else begin
					item_valid <= 1'b0;
				end
			end
			text_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	function automatic logic [7:0] pick_byte(input int kind);
		logic [7:0] b;
		case (kind)
			0: b = 8'($urandom_range(8'h20, 8'h7E));
			1: b = 8'($urandom_range(8'hA0, 8'hFE));
			2: b = 8'($urandom_range(8'h00, 8'h1F));
			3: b = 8'($urandom_range(8'h7F, 8'h9F));
			4: b = 8'hFF;
			default: b = 8'($urandom_range(255));
		endcase
		return b;
	endfunction

	task automatic queue_byte(input logic [7:0] b, input logic eob);
		item_t r;
		r.in_byte       = b;
		r.end_of_buffer = eob;
		pending_bytes.push_back(r);
		bytes_queued++;
	endtask

	// buffers of mixed runs; a few are left without an end mark
	task automatic queue_random_bytes(input int count);
		int len;
		int kind;
		logic mark_end;
		int done;
		done = 0;
		kind = 5;
		while (done < count) begin
			len      = $urandom_range(1, 8);
			mark_end = ($urandom_range(9) != 0);
			for (int i = 0; i < len; i++) begin
				if ($urandom_range(99) < 45) begin
					kind = $urandom_range(5);
				end
				queue_byte(pick_byte(kind), mark_end && (i == len - 1));
			end
			done += len;
		end
	endtask

	task automatic drain_phase();
		while (bytes_taken != bytes_queued || expected_text.size() != 0) begin
			@(negedge clk);
		end
	endtask

	initial begin
		arst_n        = 1'b0;
		item_valid    = 1'b0;
		item          = '0;
		text_stall    = 1'b0;
		item_taken    = 1'b0;
		run_open      = 1'b0;
		idle_pct      = 0;
		stall_pct     = 0;
		errors        = 0;
		bytes_queued  = 0;
		bytes_taken   = 0;
		chars_checked = 0;
		escaped_bytes = 0;
		buffers_closed = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// range edges, run open/close by byte and by end mark, 0xFF
		queue_byte(8'h41, 1'b0);
		queue_byte(8'h00, 1'b0);
		queue_byte(8'h1F, 1'b0);
		queue_byte(8'h7F, 1'b0);
		queue_byte(8'h20, 1'b0);
		queue_byte(8'h9F, 1'b1);
		queue_byte(8'hFF, 1'b0);
		queue_byte(8'h7E, 1'b0);
		queue_byte(8'hA0, 1'b0);
		queue_byte(8'hFE, 1'b1);
		queue_byte(8'h80, 1'b0);
		queue_byte(8'hFF, 1'b1);
		queue_byte(8'h0A, 1'b0);
		queue_byte(8'h5A, 1'b1);
		// run left open with no end mark, continues into the next bytes
		queue_byte(8'h9A, 1'b0);
		queue_byte(8'h1B, 1'b0);
		queue_byte(8'h01, 1'b0);
		queue_byte(8'hE9, 1'b1);
		queue_byte(8'h55, 1'b0);
		queue_byte(8'hAA, 1'b1);
		queue_random_bytes(40);
		drain_phase();

		idle_pct  = 47;
		stall_pct = 0;
		queue_random_bytes(55);
		drain_phase();

		idle_pct  = 0;
		stall_pct = 47;
		queue_random_bytes(55);
		drain_phase();

		idle_pct  = 28;
		stall_pct = 28;
		queue_random_bytes(55);
		drain_phase();

		stall_pct = 0;
		repeat (10) @(negedge clk);
		$display("Checked %0d bytes (%0d escaped, %0d end marks) and %0d characters",
			bytes_taken, escaped_bytes, buffers_closed, chars_checked);
		$display("over four phases of input idling and output stalling; %0d mismatches",
			errors);
		if (errors == 0 && expected_text.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("Timed out with %0d characters still expected", expected_text.size());
		$display("RESULT: ERROR");
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/phre_pkg.sv
rtl/phre_front.sv
rtl/phre_queue.sv
rtl/phre_back.sv
rtl/printable_run_hex_escaper.sv
tb/tb_top.sv
